// File: design/mbp_pkg.sv
// Shared constants for the MSB-first bit packer.
package mbp_pkg;

  localparam int VALUE_W       = 32;  // code value field
  localparam int LEN_W         = 6;   // code length field
  localparam int BYTE_W        = 8;
  localparam int PEND_CNT_W    = 3;   // held bit count, 0..7
  localparam int MAX_CODE_BITS = 32;
  localparam int QUEUE_DEPTH   = 2;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_FLUSH = 1'b1
  } mode_t;

endpackage

// File: design/mbp_in_if.sv
// Input channel: code write or flush request.
interface mbp_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [mbp_pkg::VALUE_W-1:0] code_value;
  logic [mbp_pkg::LEN_W-1:0]   code_length;

  modport source (output valid, output mode, output code_value, output code_length,
                  input ready);
  modport sink   (input valid, input mode, input code_value, input code_length,
                  output ready);
endinterface

// File: design/mbp_out_if.sv
// Output channel: one packed byte per word.
interface mbp_out_if;
  logic                       valid;
  logic                       ready;
  logic [mbp_pkg::BYTE_W-1:0] out_byte;
  logic                       last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

// File: design/msb_first_bit_packer.sv
// Top level of the MSB-first bit packer.
// Channels: code_in takes words with mode, code_value and code_length; a write
// appends the low code_length bits (saturated to MAX_CODE_BITS) of code_value,
// a flush pads the held bits with zeros to a byte. byte_out delivers the packed
// stream one byte per word, earliest bit in the MSB, with last_byte set on the
// final byte caused by each input word.
// Throughput: the front end takes one word per cycle while the two-entry byte
// queue has room; the back end sends one byte per cycle while byte_out.ready is
// high, and a word completes 0 to 4 bytes at 32-bit codes. Words that complete
// no byte put nothing in the queue. Sustained rate is set by the output: one
// byte per cycle while the receiver is ready. A word's bytes are registered in
// the queue on acceptance and are sent once their group reaches its head.
// Reset (rst, synchronous) drops the held bits and empties the queue.
// When the receiver stalls, the current byte holds steady; the queue fills
// and code_in.ready drops until a byte group drains.
module msb_first_bit_packer #(
  parameter int MAX_CODE_BITS = mbp_pkg::MAX_CODE_BITS,
  localparam int ACC_W  = MAX_CODE_BITS + 7,
  localparam int NB_MAX = ACC_W / 8,
  localparam int NB_W   = $clog2(NB_MAX + 1),
  localparam int DATA_W = NB_MAX * 8
) (
  input  logic      clk,
  input  logic      rst,
  mbp_in_if.sink    code_in,
  mbp_out_if.source byte_out
);

  logic                   push, full, pop, q_valid;
  logic [DATA_W-1:0]      push_data;
  logic [NB_W-1:0]        push_nbytes;
  logic [DATA_W+NB_W-1:0] head;

  mbp_front #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .code_in     (code_in),
    .full        (full),
    .push        (push),
    .push_data   (push_data),
    .push_nbytes (push_nbytes)
  );

  mbp_queue #(.WIDTH(DATA_W + NB_W), .DEPTH(mbp_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_data, push_nbytes}),
    .full      (full),
    .pop       (pop),
    .valid     (q_valid),
    .head      (head)
  );

  mbp_back #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (head[DATA_W+NB_W-1:NB_W]),
    .q_nbytes (head[NB_W-1:0]),
    .pop      (pop),
    .byte_out (byte_out)
  );

endmodule

// File: design/mbp_front.sv
// Front end: merges codes with the held bits and queues the completed bytes.
module mbp_front #(
  parameter int MAX_CODE_BITS = mbp_pkg::MAX_CODE_BITS,
  localparam int ACC_W  = MAX_CODE_BITS + 7,
  localparam int NB_MAX = ACC_W / 8,
  localparam int NB_W   = $clog2(NB_MAX + 1),
  localparam int DATA_W = NB_MAX * 8,
  localparam int TOT_W  = $clog2(ACC_W + 1)
) (
  input  logic              clk,
  input  logic              rst,
  mbp_in_if.sink            code_in,
  input  logic              full,
  output logic              push,
  output logic [DATA_W-1:0] push_data,
  output logic [NB_W-1:0]   push_nbytes
);

  logic [mbp_pkg::BYTE_W-1:0]     pending_bits, pending_bits_next;
  logic [mbp_pkg::PEND_CNT_W-1:0] pending_count, pending_count_next;

  logic [mbp_pkg::LEN_W-1:0]   len_sat;
  logic [mbp_pkg::VALUE_W-1:0] value_m;
  logic [6:0]                  held;
  logic [ACC_W-1:0]            acc;
  logic [TOT_W-1:0]            total;
  logic [2:0]                  rem;
  logic                        fire;

  assign code_in.ready = !full;
  assign fire = code_in.valid && code_in.ready;

  always_comb begin
    len_sat = code_in.code_length;
    if (code_in.code_length > mbp_pkg::LEN_W'(MAX_CODE_BITS)) begin
      len_sat = mbp_pkg::LEN_W'(MAX_CODE_BITS);
    end
    // shifting past the top leaves the mask all ones
    value_m = code_in.code_value & ~({mbp_pkg::VALUE_W{1'b1}} << len_sat);
    held    = 7'(pending_bits >> (4'd8 - {1'b0, pending_count}));
    acc     = (ACC_W'(held) << len_sat) | ACC_W'(value_m);
    total   = TOT_W'(pending_count) + TOT_W'(len_sat);
    rem     = total[2:0];
  end

  always_comb begin
    push               = 1'b0;
    push_data          = DATA_W'(acc >> rem);
    push_nbytes        = NB_W'(total >> 3);
    pending_bits_next  = pending_bits;
    pending_count_next = pending_count;
    if (fire) begin
      if (code_in.mode == mbp_pkg::MODE_FLUSH) begin
        push               = (pending_count != '0);
        push_data          = DATA_W'(pending_bits);
        push_nbytes        = NB_W'(1);
        pending_bits_next  = '0;
        pending_count_next = '0;
      end else begin
        push               = (push_nbytes != '0);
        // keep the leftover low bits, moved to the top of the byte
        pending_bits_next  = 8'(acc[7:0] << (4'd8 - {1'b0, rem}));
        pending_count_next = rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
    end else begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
    end
  end

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    fire && code_in.mode == mbp_pkg::MODE_FLUSH |=> pending_count == '0 && pending_bits == '0)
    else $error("flush left bits pending");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");
  a_pending_low_clear: assert property (@(posedge clk) disable iff (rst)
    (pending_bits << pending_count) == '0)
    else $error("unused pending bits not zero");

endmodule

// File: design/mbp_queue.sv
// Short queue of byte groups between the front and back ends.
module mbp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mbp_pkg::QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] head
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign head    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count out of range");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("queue count lost a push");

endmodule

// File: design/mbp_back.sv
// Back end: sends the queued bytes one per word, highest byte first.
module mbp_back #(
  parameter int MAX_CODE_BITS = mbp_pkg::MAX_CODE_BITS,
  localparam int ACC_W  = MAX_CODE_BITS + 7,
  localparam int NB_MAX = ACC_W / 8,
  localparam int NB_W   = $clog2(NB_MAX + 1),
  localparam int DATA_W = NB_MAX * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  logic [DATA_W-1:0] q_data,
  input  logic [NB_W-1:0]   q_nbytes,
  output logic              pop,
  mbp_out_if.source         byte_out
);

  logic [NB_W-1:0] sent, sent_next;
  logic [NB_W-1:0] sel;
  logic            last;
  logic            fire;

  always_comb begin
    sel                = q_nbytes - sent - 1'b1;
    last               = (sent == q_nbytes - 1'b1);
    byte_out.valid     = q_valid;
    byte_out.out_byte  = 8'(q_data >> {sel, 3'b000});
    byte_out.last_byte = last;
    fire               = byte_out.valid && byte_out.ready;
    pop                = fire && last;
    sent_next          = sent;
    if (fire) begin
      sent_next = last ? '0 : sent + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sent <= '0;
    end else begin
      sent <= sent_next;
    end
  end

  a_nonempty_group: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> q_nbytes != '0)
    else $error("empty byte group queued");
  a_sent_range: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> sent < q_nbytes)
    else $error("byte index past group");
  a_restart: assert property (@(posedge clk) disable iff (rst)
    pop |=> sent == '0)
    else $error("byte index not cleared after last byte");

endmodule
